/* rtl/core/assert_macros.svh */
// Shared assertion macros; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define KMP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Consequent checked in the clock cycle after the antecedent.
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/kmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

	typedef struct packed {
		logic       command;
		logic [7:0] symbol;
		logic       first;
	} kmp_in_t;

	typedef struct packed {
		logic        match;
		logic [31:0] match_start;
		logic [1:0]  status;
	} kmp_out_t;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_FULL       = 2'd1;
	localparam logic [1:0] STATUS_NO_PATTERN = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PAT_FULL,
		OP_PAT_FIRST,
		OP_PAT_START,
		OP_TXT_NOPAT,
		OP_TXT_START,
		OP_FALL_LOAD,
		OP_CHAIN,
		OP_FINISH
	} kmp_op_t;

	typedef struct packed {
		kmp_op_t op;
		logic    emit;
	} kmp_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic len_full;
		logic j0_at_len;
		logic chain_go;
	} kmp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/kmp_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface kmp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/kmp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kmp_ctrl import kmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_command,
	input  logic      in_first,
	output logic      out_valid,
	input  logic      out_ready,
	input  kmp_stat_t stat,
	output kmp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FALL,
		S_COMPARE
	} state_t;

	state_t  state_q;
	state_t  state_d;
	logic    out_valid_q;
	logic    accept;
	logic    emit;
	kmp_op_t op;

	always_comb begin
		in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
		accept   = in_valid && in_ready;
		op       = OP_NONE;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_command == CMD_PATTERN) begin
						// a new pattern always restarts at entry zero
						if (in_first || stat.len_zero) begin
							op = OP_PAT_FIRST;
						end else if (stat.len_full) begin
							op = OP_PAT_FULL;
						end else begin
							op      = OP_PAT_START;
							state_d = S_COMPARE;
						end
					end else begin
						if (stat.len_zero) begin
							op = OP_TXT_NOPAT;
						end else begin
							op      = OP_TXT_START;
							state_d = stat.j0_at_len ? S_FALL : S_COMPARE;
						end
					end
				end
			end
			S_FALL: begin
				op      = OP_FALL_LOAD;
				state_d = S_COMPARE;
			end
			S_COMPARE: begin
				if (stat.chain_go) begin
					op = OP_CHAIN;
				end else begin
					op      = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		emit = op inside {OP_PAT_FULL, OP_PAT_FIRST, OP_TXT_NOPAT, OP_FINISH};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign cmd.op    = op;
	assign cmd.emit  = emit;

	`KMP_ASSERT(a_no_overwrite, emit |-> (!out_valid_q || out_ready), "result word overwritten")
	`KMP_ASSERT(a_busy_empty, (state_q != S_IDLE) |-> !out_valid_q, "result held while busy")
	`KMP_ASSERT_NEXT(a_result_shown, emit, out_valid_q, "result word not presented")

endmodule

`default_nettype wire

/* rtl/core/kmp_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kmp_dp import kmp_pkg::*; #(
	parameter int MAX_PATTERN   = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  kmp_in_t   item,
	input  kmp_cmd_t  cmd,
	output kmp_stat_t stat,
	output kmp_out_t  result
);

	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [7:0]       store_mem [MAX_PATTERN];
	logic [IDX_W-1:0] fail_mem  [MAX_PATTERN];

	logic [LEN_W-1:0]         len_q;
	logic [IDX_W-1:0]         prefix_q;
	logic [LEN_W-1:0]         matched_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [LEN_W-1:0]         j_q;
	logic [7:0]               sym_q;
	logic                     text_mode_q;
	logic [7:0]               store_rd_q;
	logic [IDX_W-1:0]         fail_rd_q;
	kmp_out_t                 result_q;

	logic [LEN_W-1:0]         matched_clamp;
	logic [LEN_W-1:0]         j0;
	logic [LEN_W-1:0]         len_m1;
	logic [LEN_W-1:0]         rd_j;
	logic [LEN_W-1:0]         rd_jm1;
	logic [LEN_W-1:0]         j_next;
	logic [IDX_W-1:0]         store_raddr;
	logic [IDX_W-1:0]         fail_raddr;
	logic                     rd_en;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [7:0]               wr_sym;
	logic [IDX_W-1:0]         wr_fail;
	logic [POSITION_BITS-1:0] start_pos;
	kmp_out_t                 result_d;

	always_comb begin
		matched_clamp = (matched_q > len_q) ? len_q : matched_q;
		j0            = item.first ? '0 : matched_clamp;
		len_m1        = len_q - LEN_W'(1);
		j_next        = j_q + LEN_W'(store_rd_q == sym_q);

		stat.len_zero  = (len_q == '0);
		stat.len_full  = (len_q == MAX_LEN);
		stat.j0_at_len = (j0 == len_q);
		stat.chain_go  = (j_q != '0) && (store_rd_q != sym_q);

		case (cmd.op)
			OP_PAT_START: rd_j = LEN_W'(prefix_q);
			OP_TXT_START: rd_j = j0;
			default:      rd_j = LEN_W'(fail_rd_q);
		endcase
		rd_jm1      = rd_j - LEN_W'(1);
		store_raddr = rd_j[IDX_W-1:0];
		// a fully matched count first steps back through the last failure entry
		if (cmd.op == OP_TXT_START && j0 == len_q) begin
			fail_raddr = len_m1[IDX_W-1:0];
		end else begin
			fail_raddr = rd_jm1[IDX_W-1:0];
		end
		rd_en = cmd.op inside {OP_PAT_START, OP_TXT_START, OP_FALL_LOAD, OP_CHAIN};

		wr_en   = (cmd.op == OP_PAT_FIRST) || (cmd.op == OP_FINISH && !text_mode_q);
		wr_addr = (cmd.op == OP_PAT_FIRST) ? '0 : len_q[IDX_W-1:0];
		wr_sym  = (cmd.op == OP_PAT_FIRST) ? item.symbol : sym_q;
		wr_fail = (cmd.op == OP_PAT_FIRST) ? '0 : j_next[IDX_W-1:0];

		start_pos = pos_q - POSITION_BITS'(len_m1);

		result_d.match       = 1'b0;
		result_d.match_start = '0;
		result_d.status      = STATUS_OK;
		case (cmd.op)
			OP_PAT_FULL:  result_d.status = STATUS_FULL;
			OP_TXT_NOPAT: result_d.status = STATUS_NO_PATTERN;
			OP_FINISH: begin
				if (text_mode_q && j_next == len_q) begin
					result_d.match       = 1'b1;
					result_d.match_start = 32'(start_pos);
				end
			end
			default: begin
				result_d.status = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_sym;
			fail_mem[wr_addr]  <= wr_fail;
		end
		if (rd_en) begin
			store_rd_q <= store_mem[store_raddr];
			fail_rd_q  <= fail_mem[fail_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PAT_START || cmd.op == OP_TXT_START) begin
			sym_q       <= item.symbol;
			text_mode_q <= (item.command == CMD_TEXT);
		end
		if (rd_en) begin
			j_q <= rd_j;
		end
		if (cmd.emit) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			prefix_q  <= '0;
			matched_q <= '0;
			pos_q     <= '0;
		end else begin
			case (cmd.op)
				OP_PAT_FIRST: begin
					len_q     <= LEN_W'(1);
					prefix_q  <= '0;
					matched_q <= '0;
				end
				OP_TXT_NOPAT: begin
					pos_q <= item.first ? POSITION_BITS'(1) : pos_q + POSITION_BITS'(1);
					if (item.first) begin
						matched_q <= '0;
					end
				end
				OP_TXT_START: begin
					if (item.first) begin
						pos_q <= '0;
					end
				end
				OP_FINISH: begin
					if (text_mode_q) begin
						matched_q <= j_next;
						pos_q     <= pos_q + POSITION_BITS'(1);
					end else begin
						prefix_q <= j_next[IDX_W-1:0];
						len_q    <= len_q + LEN_W'(1);
					end
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	assign result = result_q;

	`KMP_ASSERT(a_len_bound, len_q <= MAX_LEN, "pattern length beyond store")
	`KMP_ASSERT(a_prefix_bound, (len_q != '0) |-> (LEN_W'(prefix_q) < len_q), "prefix run too long")
	`KMP_ASSERT(a_matched_bound, matched_q <= len_q, "matched count beyond pattern")

endmodule

`default_nettype wire

/* rtl/core/kmp_stream_matcher.sv */
// Result timing: store-full, first pattern byte and text with no pattern give their word
// in the cycle after acceptance; other bytes repeat the compare state once per
// failure-chain step, a text byte following a full match passing through fall-back first.
// A new byte is taken only in the idle state, with the result word free or being read;
// the registered-read pattern and failure memories are walked one chain step per cycle.
// Reset (arst_n low) clears pattern length, prefix run, match count and text position.
`timescale 1ns / 1ps
`default_nettype none

module kmp_stream_matcher import kmp_pkg::*; #(
	parameter int MAX_PATTERN   = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	kmp_stream_if.sink   items,
	kmp_stream_if.source results
);

	kmp_cmd_t  cmd;
	kmp_stat_t stat;
	kmp_out_t  result;
	kmp_in_t   item;

	assign item = items.data;

	kmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_ready   (items.ready),
		.in_command (item.command),
		.in_first   (item.first),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	kmp_dp #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	assign results.data = result;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import kmp_pkg::*;

	localparam int PATTERN_DEPTH = 64;
	localparam int RANDOM_WORDS  = 1250;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 100;

	typedef struct {
		logic       cmd;
		logic [7:0] sym;
		logic       first;
		int         reps;
		bit         typed;
		kmp_out_t   want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	kmp_stream_if #(.T(kmp_in_t))  items ();
	kmp_stream_if #(.T(kmp_out_t)) results ();

	kmp_stream_matcher #(
		.MAX_PATTERN(PATTERN_DEPTH),
		.POSITION_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0]  pat_mem [PATTERN_DEPTH];
	int unsigned fail_mem [PATTERN_DEPTH];
	int unsigned pat_len    = 0;
	int unsigned prefix_len = 0;
	int unsigned match_len  = 0;
	logic [31:0] text_pos   = '0;

	kmp_out_t expected_words [$];
	dir_row_t dir_rows [$];

	// typed-in expectation travelling alongside the offered word
	logic     typed_ok;
	kmp_out_t typed_word;

	int fail_count  = 0;
	int idle_cycles = 0;
	int words_sent  = 0;
	int burst_left  = 0;

	logic [15:0] stall_mask  = '1;
	logic [3:0]  stall_phase = '0;
	int          hold_cnt    = 0;
	bit          hold_done   = 1'b0;
	bit          hold_req    = 1'b0;

	function automatic kmp_out_t scan_word(input kmp_in_t w);
		kmp_out_t    o;
		int unsigned r;
		o = '0;
		o.status = STATUS_OK;
		if (w.command == CMD_PATTERN) begin
			if (w.first) begin
				pat_len    = 0;
				prefix_len = 0;
				match_len  = 0;
			end
			if (pat_len >= PATTERN_DEPTH) begin
				o.status = STATUS_FULL;
			end else begin
				pat_mem[pat_len] = w.symbol;
				if (pat_len == 0) begin
					fail_mem[0] = 0;
					prefix_len  = 0;
				end else begin
					r = prefix_len;
					while (r > 0 && pat_mem[r] != w.symbol)
						r = fail_mem[r - 1];
					if (pat_mem[r] == w.symbol)
						r++;
					fail_mem[pat_len] = r;
					prefix_len = r;
				end
				pat_len++;
			end
		end else begin
			if (w.first) begin
				match_len = 0;
				text_pos  = '0;
			end
			if (pat_len == 0) begin
				o.status = STATUS_NO_PATTERN;
			end else begin
				r = (match_len > pat_len) ? pat_len : match_len;
				// after a full match carry on from the border so overlaps are found
				if (r == pat_len)
					r = fail_mem[pat_len - 1];
				while (r > 0 && pat_mem[r] != w.symbol)
					r = fail_mem[r - 1];
				if (pat_mem[r] == w.symbol)
					r++;
				if (r == pat_len) begin
					o.match       = 1'b1;
					o.match_start = text_pos - 32'(pat_len - 1);
				end
				match_len = r;
			end
			text_pos = text_pos + 32'd1;
		end
		return o;
	endfunction

	function automatic void add_row(input logic cmd, input logic [7:0] sym, input logic first,
			input int reps = 1, input bit typed = 1'b0, input logic m = 1'b0,
			input logic [31:0] pos = '0, input logic [1:0] stat = STATUS_OK);
		dir_row_t r;
		r.cmd              = cmd;
		r.sym              = sym;
		r.first            = first;
		r.reps             = reps;
		r.typed            = typed;
		r.want.match       = m;
		r.want.match_start = pos;
		r.want.status      = stat;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	task automatic send_word(input logic cmd, input logic [7:0] sym, input logic first,
			input bit typed = 1'b0, input kmp_out_t want = '0);
		kmp_in_t w;
		w.command = cmd;
		w.symbol  = sym;
		w.first   = first;
		if (burst_left == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		items.valid <= 1'b1;
		items.data  <= w;
		typed_ok    <= typed;
		typed_word  <= want;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	always @(posedge clk) begin : monitor
		kmp_out_t want;
		kmp_out_t got;
		logic     moved;
		moved = 1'b0;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				moved = 1'b1;
				got   = results.data;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: match %0d start %0d status %0d",
						got.match, got.match_start, got.status);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got.match !== want.match) begin
						$error("match: expected %0d, got %0d", want.match, got.match);
						fail_count++;
					end
					if (got.match_start !== want.match_start) begin
						$error("match_start: expected %0d, got %0d",
							want.match_start, got.match_start);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
				end
			end
			if (items.valid && items.ready) begin
				moved = 1'b1;
				want  = scan_word(items.data);
				expected_words.insert(expected_words.size(), typed_ok ? typed_word : want);
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: rotating stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt      <= hold_cnt - 1;
			results.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done     <= 1'b1;
			hold_cnt      <= HOLD_CYCLES;
			results.ready <= 1'b0;
		end else begin
			results.ready <= stall_mask[stall_phase];
			stall_phase   <= stall_phase + 4'd1;
			if (stall_phase == 4'hf)
				stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hffff
					: 16'($urandom | $urandom);
		end
	end

	initial begin : stimulus
		logic [7:0] pat_q [$];
		logic [7:0] base;
		logic [7:0] s;
		int         span;
		int         plen;
		int         tlen;
		int         n;
		int         pick;
		int         dir_count;
		bit         fresh;
		arst_n      <= 1'b0;
		items.valid <= 1'b0;
		items.data  <= '0;
		typed_ok    <= 1'b0;
		typed_word  <= '0;

		// text before any pattern
		add_row(CMD_TEXT, 8'h00, 1'b1, 1, 1'b1, 1'b0, 0, STATUS_NO_PATTERN);
		add_row(CMD_TEXT, 8'hff, 1'b0, 1, 1'b1, 1'b0, 0, STATUS_NO_PATTERN);
		// pattern "aba", overlapping hits in "ababa"
		add_row(CMD_PATTERN, 8'h61, 1'b1, 1, 1'b1);
		add_row(CMD_PATTERN, 8'h62, 1'b0, 1, 1'b1);
		add_row(CMD_PATTERN, 8'h61, 1'b0, 1, 1'b1);
		add_row(CMD_TEXT, 8'h61, 1'b1);
		add_row(CMD_TEXT, 8'h62, 1'b0);
		add_row(CMD_TEXT, 8'h61, 1'b0, 1, 1'b1, 1'b1, 0, STATUS_OK);
		add_row(CMD_TEXT, 8'h62, 1'b0);
		add_row(CMD_TEXT, 8'h61, 1'b0, 1, 1'b1, 1'b1, 2, STATUS_OK);
		// pattern grows while a partial match is held
		add_row(CMD_PATTERN, 8'h61, 1'b0);
		add_row(CMD_TEXT, 8'h61, 1'b0);
		add_row(CMD_TEXT, 8'h00, 1'b0);
		// extreme byte values
		add_row(CMD_PATTERN, 8'h00, 1'b1, 1, 1'b1);
		add_row(CMD_PATTERN, 8'hff, 1'b0, 1, 1'b1);
		add_row(CMD_TEXT, 8'hff, 1'b1);
		add_row(CMD_TEXT, 8'h00, 1'b0);
		add_row(CMD_TEXT, 8'hff, 1'b0, 1, 1'b1, 1'b1, 1, STATUS_OK);
		// single-byte pattern, match on every byte
		add_row(CMD_PATTERN, 8'hff, 1'b1, 1, 1'b1);
		add_row(CMD_TEXT, 8'hff, 1'b1, 1, 1'b1, 1'b1, 0, STATUS_OK);
		add_row(CMD_TEXT, 8'hff, 1'b0, 1, 1'b1, 1'b1, 1, STATUS_OK);
		// fill the store, then overflow it
		add_row(CMD_PATTERN, 8'h5a, 1'b1, 1, 1'b1);
		add_row(CMD_PATTERN, 8'h5a, 1'b0, PATTERN_DEPTH - 1, 1'b1);
		add_row(CMD_PATTERN, 8'h33, 1'b0, 1, 1'b1, 1'b0, 0, STATUS_FULL);
		add_row(CMD_PATTERN, 8'ha5, 1'b0, 1, 1'b1, 1'b0, 0, STATUS_FULL);
		add_row(CMD_TEXT, 8'h5a, 1'b1, 70);
		add_row(CMD_PATTERN, 8'hc3, 1'b1, 1, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			for (int k = 0; k < dir_rows[i].reps; k++)
				send_word(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].first,
					dir_rows[i].typed, dir_rows[i].want);
		dir_count = words_sent;

		while (words_sent < dir_count + RANDOM_WORDS) begin
			if (words_sent > dir_count + 600 && !hold_req)
				hold_req <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				// noise
				repeat ($urandom_range(1, 8))
					send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 3) == 0);
			end else begin
				// small alphabet so that hits are frequent
				base = 8'($urandom_range(0, 253));
				span = $urandom_range(1, 2);
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70)
					: $urandom_range(1, 6);
				pat_q.delete();
				for (int i = 0; i < plen; i++) begin
					s = base + 8'($urandom_range(0, span));
					if (pat_q.size() < PATTERN_DEPTH)
						pat_q.insert(pat_q.size(), s);
					send_word(CMD_PATTERN, s, i == 0);
				end
				tlen  = (plen > 6) ? $urandom_range(80, 160) : $urandom_range(4, 40);
				fresh = $urandom_range(0, 4) != 0;
				n = 0;
				while (n < tlen) begin
					pick = $urandom_range(0, 9);
					if (pick < 3) begin
						foreach (pat_q[k]) begin
							send_word(CMD_TEXT, pat_q[k], fresh && n == 0);
							n++;
						end
					end else if (pick == 3) begin
						s = base + 8'($urandom_range(0, span));
						if (pat_q.size() < PATTERN_DEPTH)
							pat_q.insert(pat_q.size(), s);
						send_word(CMD_PATTERN, s, 1'b0);
					end else begin
						send_word(CMD_TEXT, base + 8'($urandom_range(0, span)),
							fresh && n == 0);
						n++;
					end
				end
			end
		end

		items.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* kmp_stream_matcher.f */
+incdir+rtl/core
rtl/core/kmp_pkg.sv
rtl/core/kmp_stream_if.sv
rtl/core/kmp_ctrl.sv
rtl/core/kmp_dp.sv
rtl/core/kmp_stream_matcher.sv
tb/testbench.sv
